[rtl/core/hlcfp_pkg.sv]
// Package for the header/length/checksum frame parser.
// Holds header constants, hunt states, status codes and the result record.
// No dependencies.
`default_nettype none

package hlcfp_pkg;

   // Header bytes and frame constants.
   localparam logic [7:0] HDR_SYNC   = 8'hFF;
   localparam logic [7:0] HDR_MID    = 8'h0B;
   localparam logic [7:0] CONTROL_ID = 8'd11;
   localparam logic [7:0] MIN_LENGTH = 8'd3;
   localparam logic [7:0] HDR_SUM    = 8'(HDR_SYNC + HDR_SYNC + HDR_MID);

   // Frame byte positions that are kept.
   localparam int POS_ID     = 3;
   localparam int POS_LENGTH = 4;
   localparam int POS_FIRST  = 5;
   localparam int POS_SECOND = 6;
   localparam int POS_THIRD  = 7;
   localparam int TAIL_BYTES = 5;

   typedef enum logic [1:0] {
      HUNT_IDLE = 2'd0,
      HUNT_ONE  = 2'd1,
      HUNT_TWO  = 2'd2
   } hunt_type;

   typedef enum logic [1:0] {
      STATUS_CONTROL_OK = 2'd0,
      STATUS_OTHER_OK   = 2'd1,
      STATUS_CHECKSUM   = 2'd2
   } status_type;

   // One finished frame, with a flag that tells whether it is present.
   typedef struct packed {
      logic       valid;
      status_type frame_status;
      logic [7:0] packet_id;
      logic [7:0] control_first;
      logic [7:0] control_second;
      logic [7:0] control_third;
   } result_type;

endpackage

`default_nettype wire

[rtl/core/hlcfp_channels.sv]
// Handshake channels of the frame parser: received bytes in, frame results out.
// No dependencies.
`default_nettype none

interface hlcfp_req_if;
   logic       valid;
   logic       ready;
   logic [7:0] rx_byte;

   modport source (output valid, output rx_byte, input ready);
   modport sink (input valid, input rx_byte, output ready);
endinterface

interface hlcfp_rsp_if;
   logic       valid;
   logic       ready;
   logic [1:0] frame_status;
   logic [7:0] packet_id;
   logic [7:0] control_first;
   logic [7:0] control_second;
   logic [7:0] control_third;

   modport source (output valid, output frame_status, output packet_id,
                   output control_first, output control_second,
                   output control_third, input ready);
   modport sink (input valid, input frame_status, input packet_id,
                 input control_first, input control_second,
                 input control_third, output ready);
endinterface

`default_nettype wire

[rtl/core/hlcfp_parse.sv]
// Frame parser state: header hunt, byte counter, running checksum, kept bytes.
// Depends on hlcfp_pkg. Gives the result a byte would cause, commits on advance.
`default_nettype none

module hlcfp_parse #(
   parameter int FRAME_CAPACITY = 22
) (
   input  wire logic                clock,
   input  wire logic                reset,
   input  wire logic                byte_valid,
   input  wire logic                advance,
   input  wire logic [7:0]          rx_byte,
   output hlcfp_pkg::result_type    result
);
   import hlcfp_pkg::*;

   localparam int CNT_W = $clog2(FRAME_CAPACITY + 1);
   localparam logic [7:0] MAX_LENGTH = 8'(FRAME_CAPACITY - TAIL_BYTES);

   hunt_type         hunt_ff, hunt_in;
   logic             in_frame_ff, in_frame_in;
   logic [CNT_W-1:0] count_ff, count_in;
   logic [7:0]       sum_ff, sum_in;
   logic [7:0]       length_ff, length_in;
   logic [7:0]       id_ff, first_ff, second_ff, third_ff;

   logic [CNT_W-1:0] count_next;
   logic [7:0]       sum_next;
   logic [8:0]       end_count;
   logic             frame_done;

   // Counter and checksum after taking this byte into the frame.
   assign count_next = count_ff + CNT_W'(1);
   assign sum_next   = sum_ff + rx_byte;
   assign end_count  = {1'b0, length_ff} + 9'(TAIL_BYTES);
   assign frame_done = in_frame_ff && (count_next > CNT_W'(POS_LENGTH + 1))
                       && (9'(count_next) >= end_count);

   // The result this byte would cause; the last byte can be byte 7 itself.
   always_comb begin
      result.valid          = byte_valid && frame_done;
      result.packet_id      = id_ff;
      result.control_first  = first_ff;
      result.control_second = second_ff;
      result.control_third  = (count_ff == CNT_W'(POS_THIRD)) ? rx_byte : third_ff;
      if (sum_next != 8'd0) begin
         result.frame_status = STATUS_CHECKSUM;
      end else if (id_ff == CONTROL_ID) begin
         result.frame_status = STATUS_CONTROL_OK;
      end else begin
         result.frame_status = STATUS_OTHER_OK;
      end
   end

   // Next state of the hunt and of the frame collection.
   always_comb begin
      hunt_in     = hunt_ff;
      in_frame_in = in_frame_ff;
      count_in    = count_ff;
      sum_in      = sum_ff;
      length_in   = length_ff;
      if (!in_frame_ff) begin
         case (hunt_ff)
            HUNT_ONE: begin
               hunt_in = (rx_byte == HDR_SYNC) ? HUNT_TWO : HUNT_IDLE;
            end
            HUNT_TWO: begin
               if (rx_byte == HDR_MID) begin
                  hunt_in     = HUNT_IDLE;
                  in_frame_in = 1'b1;
                  count_in    = CNT_W'(POS_ID);
                  sum_in      = HDR_SUM;
                  length_in   = 8'd0;
               end else if (rx_byte != HDR_SYNC) begin
                  hunt_in = HUNT_IDLE;
               end
            end
            default: begin
               hunt_in = (rx_byte == HDR_SYNC) ? HUNT_ONE : HUNT_IDLE;
            end
         endcase
      end else begin
         count_in = count_next;
         sum_in   = sum_next;
         if (count_ff == CNT_W'(POS_LENGTH)) begin
            length_in = rx_byte;
            if (rx_byte < MIN_LENGTH || rx_byte > MAX_LENGTH) begin
               in_frame_in = 1'b0;
            end
         end else if (frame_done) begin
            in_frame_in = 1'b0;
         end
      end
   end

   // Control state, cleared by reset.
   always_ff @(posedge clock) begin
      if (reset) begin
         hunt_ff     <= HUNT_IDLE;
         in_frame_ff <= 1'b0;
         count_ff    <= '0;
         sum_ff      <= '0;
         length_ff   <= '0;
      end else if (advance) begin
         hunt_ff     <= hunt_in;
         in_frame_ff <= in_frame_in;
         count_ff    <= count_in;
         sum_ff      <= sum_in;
         length_ff   <= length_in;
      end
   end

   // Kept frame bytes; each is rewritten in every frame before it is read.
   always_ff @(posedge clock) begin
      if (advance && in_frame_ff) begin
         case (count_ff)
            CNT_W'(POS_ID):     id_ff     <= rx_byte;
            CNT_W'(POS_FIRST):  first_ff  <= rx_byte;
            CNT_W'(POS_SECOND): second_ff <= rx_byte;
            CNT_W'(POS_THIRD):  third_ff  <= rx_byte;
            default: ;
         endcase
      end
   end

endmodule

`default_nettype wire

[rtl/core/hlcfp_out_reg.sv]
// Result register of the frame parser, driving the response channel.
// Depends on hlcfp_pkg and hlcfp_rsp_if.
`default_nettype none

module hlcfp_out_reg (
   input  wire logic                  clock,
   input  wire logic                  reset,
   input  wire logic                  load,
   input  wire hlcfp_pkg::result_type result,
   output logic                       out_free,
   hlcfp_rsp_if.source                rsp_chan
);
   import hlcfp_pkg::*;

   logic       valid_ff;
   result_type data_ff;

   // The register can take a new beat when empty or when it drains now.
   assign out_free = !valid_ff || rsp_chan.ready;

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else if (out_free) begin
         valid_ff <= load;
      end
   end

   always_ff @(posedge clock) begin
      if (out_free && load) begin
         data_ff <= result;
      end
   end

   assign rsp_chan.valid          = valid_ff;
   assign rsp_chan.frame_status   = data_ff.frame_status;
   assign rsp_chan.packet_id      = data_ff.packet_id;
   assign rsp_chan.control_first  = data_ff.control_first;
   assign rsp_chan.control_second = data_ff.control_second;
   assign rsp_chan.control_third  = data_ff.control_third;

endmodule

`default_nettype wire

[rtl/core/header_length_checksum_frame_parser_unit.sv]
// Top level of the header/length/checksum frame parser.
// Depends on hlcfp_pkg, the channel interfaces, hlcfp_parse and hlcfp_out_reg.
//
// Usage: each beat on req_chan carries one received byte. The unit hunts for
// the header FF FF 0B, then collects the packet id (byte 3), the length L
// (byte 4) and L+5 bytes in all, the last one a checksum that makes the sum
// of all bytes zero mod 256. A length below 3 or above FRAME_CAPACITY-5 drops
// the frame and restarts the hunt. The beat carrying a frame's last byte
// produces one beat on rsp_chan with the status, packet id and bytes 5 to 7;
// every other byte produces none.
// Throughput: one byte per cycle unless a result waits for a full result
// register; counter, checksum and hunt state update between the input
// register and the result register. A frame's last byte passes the input
// register, then its result is loaded into the register driving rsp_chan.
// Reset (synchronous) empties both registers and returns to the hunt.
// When the receiver stalls, bytes that produce no result keep flowing; a byte
// that would produce a result waits in the input register until the result
// register is free, and req_chan.ready stays low while it waits.
`default_nettype none

module header_length_checksum_frame_parser_unit #(
   parameter int FRAME_CAPACITY = 22
) (
   input  wire logic   clock,
   input  wire logic   reset,
   hlcfp_req_if.sink   req_chan,
   hlcfp_rsp_if.source rsp_chan
);
   import hlcfp_pkg::*;

   logic       in_valid_ff;
   logic [7:0] in_byte_ff;
   logic       advance;
   logic       out_free;
   result_type pending;

   // A byte moves on unless its result finds the result register full.
   assign advance        = in_valid_ff && (!pending.valid || out_free);
   assign req_chan.ready = !in_valid_ff || advance;

   // Input register.
   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff <= 1'b0;
      end else if (req_chan.ready) begin
         in_valid_ff <= req_chan.valid;
      end
   end

   always_ff @(posedge clock) begin
      if (req_chan.ready && req_chan.valid) begin
         in_byte_ff <= req_chan.rx_byte;
      end
   end

   hlcfp_parse #(
      .FRAME_CAPACITY(FRAME_CAPACITY)
   ) u_parse (
      .clock      (clock),
      .reset      (reset),
      .byte_valid (in_valid_ff),
      .advance    (advance),
      .rx_byte    (in_byte_ff),
      .result     (pending)
   );

   hlcfp_out_reg u_out_reg (
      .clock    (clock),
      .reset    (reset),
      .load     (advance && pending.valid),
      .result   (pending),
      .out_free (out_free),
      .rsp_chan (rsp_chan)
   );

endmodule

`default_nettype wire
